/* rtl/sha256md_pkg.sv */
package sha256md_pkg;

  localparam int unsigned BlockBits = 512;
  localparam int unsigned CountBits = 61;

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  localparam logic [31:0] InitHash [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [7:0] PadMark    = 8'h80;
  localparam logic [5:0] LenStart   = 6'd56;
  localparam logic [5:0] FillLast   = 6'd63;
  localparam logic [5:0] RoundLast  = 6'd63;
  localparam logic [5:0] SchedStart = 6'd16;

  // byte source for the block register
  typedef enum logic [1:0] {
    BSEL_INPUT,
    BSEL_MARK,
    BSEL_ZERO,
    BSEL_LEN
  } byte_sel_e;

  typedef struct packed {
    logic      byte_en;
    byte_sel_e byte_sel;
    logic [2:0] len_idx;
    logic      round_en;
    logic [5:0] round_idx;
    logic      final_en;
    logic      emit;
  } sha_cmd_t;

  typedef struct packed {
    logic [5:0] fill;
    logic       out_busy;
  } sha_sts_t;

  function automatic logic [31:0] ror32(input logic [31:0] x, input logic [4:0] n);
    ror32 = (x >> n) | (x << (6'd32 - {1'b0, n}));
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = ror32(x, 5'd2) ^ ror32(x, 5'd13) ^ ror32(x, 5'd22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = ror32(x, 5'd6) ^ ror32(x, 5'd11) ^ ror32(x, 5'd25);
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = ror32(x, 5'd7) ^ ror32(x, 5'd18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = ror32(x, 5'd17) ^ ror32(x, 5'd19) ^ (x >> 10);
  endfunction

endpackage

/* rtl/sha256_message_digest_top.sv */
// SHA-256 digest engine, byte-serial input.
// Input request: data_byte_i/has_byte_i/last_i on in_valid_i/in_ready_o. A
// request with has_byte_i = 0 carries no byte; with last_i = 1 it closes the
// message (the empty message is a lone request with last_i = 1).
// Output request: eight words on out_valid_o/out_ready_i, h0 first, with
// word_index_o, last_word_o on h7 and too_long_o set when the message
// ran past 2^61-1 bytes.
// Flow: byte requests are taken only in the idle state; the 64th byte of a
// block starts the 64 compression rounds, one per cycle, plus the chaining add,
// and no request is taken until they finish. After last_i the pad bytes go in
// one per cycle and one or two blocks are compressed before the first digest
// word shows.
// The digest is copied into an output buffer, so the next message is taken
// while the receiver drains the words; only if the next digest is done
// before the buffer empties does the engine wait in its final step.
// Reset (rst_ni low, async) loads the initial hash, clears the counters and
// drops out_valid_o.
module sha256_message_digest_top
  import sha256md_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  output logic        too_long_o
);

  sha_cmd_t cmd;
  sha_sts_t sts;

  // sequencer: byte intake, padding, round count, final add
  sha256md_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .has_byte_i (has_byte_i),
    .last_i     (last_i),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // block shift register, round logic, chaining value, digest buffer
  sha256md_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .data_byte_i    (data_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .digest_word_o  (digest_word_o),
    .word_index_o   (word_index_o),
    .last_word_o    (last_word_o),
    .too_long_o     (too_long_o)
  );

endmodule

/* rtl/sha256md_dp.sv */
module sha256md_dp
  import sha256md_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  sha_cmd_t    cmd_i,
  output sha_sts_t    sts_o,
  input  logic [7:0]  data_byte_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o,
  output logic        too_long_o
);

  logic [BlockBits-1:0] blk_q, blk_d;
  logic [31:0]          work_q [8];
  logic [31:0]          work_d [8];
  logic [31:0]          chain_q [8];
  logic [31:0]          chain_d [8];
  logic [31:0]          obuf_q [8];
  logic [31:0]          sum [8];
  logic [CountBits-1:0] cnt_q, cnt_d;
  logic [5:0]           fill_q, fill_d;
  logic                 ovf_q, ovf_d;
  logic                 out_vld_q, out_err_q;
  logic [2:0]           out_idx_q;
  logic [63:0]          len_bits;
  logic [7:0]           new_byte;
  logic [31:0]          w_t, t1, t2;
  logic                 blk_done;

  assign len_bits = {cnt_q, 3'b000};
  assign blk_done = cmd_i.byte_en && (fill_q == FillLast);

  always_comb begin
    case (cmd_i.byte_sel)
      BSEL_INPUT: new_byte = data_byte_i;
      BSEL_MARK:  new_byte = PadMark;
      BSEL_ZERO:  new_byte = 8'h00;
      BSEL_LEN:   new_byte = len_bits[{~cmd_i.len_idx, 3'b000} +: 8];
      default:    new_byte = 8'h00;
    endcase
  end

  // message schedule: blk_q[511:480] is W[t-16], shifting one word per round
  always_comb begin
    if (cmd_i.round_idx < SchedStart) begin
      w_t = blk_q[511:480];
    end else begin
      w_t = blk_q[511:480] + small_sig0(blk_q[479:448]) + blk_q[223:192]
            + small_sig1(blk_q[63:32]);
    end
  end

  assign t1 = work_q[7] + big_sig1(work_q[4])
              + ((work_q[4] & work_q[5]) ^ (~work_q[4] & work_q[6]))
              + RoundK[cmd_i.round_idx] + w_t;
  assign t2 = big_sig0(work_q[0])
              + ((work_q[0] & work_q[1]) ^ (work_q[0] & work_q[2]) ^ (work_q[1] & work_q[2]));

  always_comb begin
    blk_d  = blk_q;
    work_d = work_q;
    for (int i = 0; i < 8; i++) begin
      sum[i] = chain_q[i] + work_q[i];
    end
    if (cmd_i.byte_en) begin
      blk_d = {blk_q[BlockBits-9:0], new_byte};
      if (blk_done) begin
        work_d = chain_q;
      end
    end else if (cmd_i.round_en) begin
      blk_d     = {blk_q[BlockBits-33:0], w_t};
      work_d[7] = work_q[6];
      work_d[6] = work_q[5];
      work_d[5] = work_q[4];
      work_d[4] = work_q[3] + t1;
      work_d[3] = work_q[2];
      work_d[2] = work_q[1];
      work_d[1] = work_q[0];
      work_d[0] = t1 + t2;
    end
  end

  always_comb begin
    chain_d = chain_q;
    cnt_d   = cnt_q;
    fill_d  = fill_q;
    ovf_d   = ovf_q;
    if (cmd_i.byte_en) begin
      fill_d = fill_q + 6'd1;
      if (cmd_i.byte_sel == BSEL_INPUT) begin
        cnt_d = cnt_q + 1'b1;
        if (&cnt_q) begin
          ovf_d = 1'b1;
        end
      end
    end
    if (cmd_i.final_en) begin
      if (cmd_i.emit) begin
        chain_d = InitHash;
        cnt_d   = '0;
        fill_d  = '0;
        ovf_d   = 1'b0;
      end else begin
        chain_d = sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q  <= blk_d;
    work_q <= work_d;
    if (cmd_i.final_en && cmd_i.emit) begin
      obuf_q <= sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_q   <= InitHash;
      cnt_q     <= '0;
      fill_q    <= '0;
      ovf_q     <= 1'b0;
      out_vld_q <= 1'b0;
      out_idx_q <= '0;
      out_err_q <= 1'b0;
    end else begin
      chain_q <= chain_d;
      cnt_q   <= cnt_d;
      fill_q  <= fill_d;
      ovf_q   <= ovf_d;
      if (cmd_i.final_en && cmd_i.emit) begin
        out_vld_q <= 1'b1;
        out_idx_q <= '0;
        out_err_q <= ovf_q;
      end else if (out_vld_q && out_ready_i) begin
        out_idx_q <= out_idx_q + 3'd1;
        if (&out_idx_q) begin
          out_vld_q <= 1'b0;
        end
      end
    end
  end

  assign sts_o.fill     = fill_q;
  assign sts_o.out_busy = out_vld_q;

  assign out_valid_o    = out_vld_q;
  assign digest_word_o  = obuf_q[out_idx_q];
  assign word_index_o   = out_idx_q;
  assign last_word_o    = &out_idx_q;
  assign too_long_o     = out_err_q;

  // length bytes always land in the last eight bytes of a block
  a_len_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.byte_en && cmd_i.byte_sel == BSEL_LEN) |-> (fill_q[5:3] == 3'b111))
    else $error("length byte outside tail of block");

  // a digest load starts a fresh message and a fresh readout
  a_emit_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.final_en && cmd_i.emit) |=> (out_vld_q && out_idx_q == 3'd0 && cnt_q == '0
                                        && fill_q == 6'd0 && !ovf_q))
    else $error("digest load did not restart state");

endmodule

/* rtl/sha256md_ctrl.sv */
module sha256md_ctrl
  import sha256md_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  logic     has_byte_i,
  input  logic     last_i,
  input  sha_sts_t sts_i,
  output sha_cmd_t cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_ROUND,
    ST_FINAL
  } state_e;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_ZERO,
    PH_LEN
  } phase_e;

  state_e     state_q, state_d;
  phase_e     phase_q, phase_d;
  logic [5:0] rnd_q, rnd_d;
  logic [2:0] len_q, len_d;
  logic       last_q, last_d;
  logic       len_done_q, len_done_d;

  always_comb begin
    state_d    = state_q;
    phase_d    = phase_q;
    rnd_d      = rnd_q;
    len_d      = len_q;
    last_d     = last_q;
    len_done_d = len_done_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.byte_sel  = BSEL_INPUT;
    cmd_o.round_idx = rnd_q;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.byte_en = has_byte_i;
          last_d        = last_i;
          len_done_d    = 1'b0;
          phase_d       = PH_MARK;
          len_d         = '0;
          if (has_byte_i && sts_i.fill == FillLast) begin
            state_d = ST_ROUND;
            rnd_d   = '0;
          end else if (last_i) begin
            state_d = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        cmd_o.byte_en = 1'b1;
        case (phase_q)
          PH_MARK: begin
            cmd_o.byte_sel = BSEL_MARK;
            phase_d        = PH_ZERO;
          end
          PH_ZERO: begin
            if (sts_i.fill == LenStart) begin
              cmd_o.byte_sel = BSEL_LEN;
              cmd_o.len_idx  = '0;
              len_d          = 3'd1;
              phase_d        = PH_LEN;
            end else begin
              cmd_o.byte_sel = BSEL_ZERO;
            end
          end
          PH_LEN: begin
            cmd_o.byte_sel = BSEL_LEN;
            cmd_o.len_idx  = len_q;
            len_d          = len_q + 3'd1;
            if (&len_q) begin
              len_done_d = 1'b1;
            end
          end
          default: begin
            cmd_o.byte_en = 1'b0;
            phase_d       = PH_MARK;
          end
        endcase
        if (sts_i.fill == FillLast) begin
          state_d = ST_ROUND;
          rnd_d   = '0;
        end
      end
      ST_ROUND: begin
        cmd_o.round_en = 1'b1;
        rnd_d          = rnd_q + 6'd1;
        if (rnd_q == RoundLast) begin
          state_d = ST_FINAL;
        end
      end
      ST_FINAL: begin
        cmd_o.emit = last_q && len_done_q;
        // hold the finished digest until the readout buffer is free
        if (!(cmd_o.emit && sts_i.out_busy)) begin
          cmd_o.final_en = 1'b1;
          if (!last_q || len_done_q) begin
            state_d = ST_IDLE;
          end else begin
            state_d = ST_PAD;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      phase_q    <= PH_MARK;
      rnd_q      <= '0;
      len_q      <= '0;
      last_q     <= 1'b0;
      len_done_q <= 1'b0;
    end else begin
      state_q    <= state_d;
      phase_q    <= phase_d;
      rnd_q      <= rnd_d;
      len_q      <= len_d;
      last_q     <= last_d;
      len_done_q <= len_done_d;
    end
  end

  // the last round always hands over to the chaining update
  a_round_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROUND && rnd_q == RoundLast) |=> (state_q == ST_FINAL))
    else $error("round count did not end in final step");

  // never overwrite a digest that is still being read out
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.final_en && cmd_o.emit) |-> !sts_i.out_busy)
    else $error("digest load while readout busy");

endmodule
